// ----- sv/cdad_pkg.sv -----
// Shared types, constants and the month length table for the date advance block.
package cdad_pkg;

    // Field widths
    localparam int DayW   = 5;
    localparam int MonthW = 4;
    localparam int YearW  = 16;
    localparam int AddW   = 16;
    // Working day count: start day plus the largest day count
    localparam int AccW   = 17;

    localparam int InDataW  = 48;
    localparam int OutDataW = 32;

    localparam logic [MonthW-1:0] MonthFeb  = 4'd2;
    localparam logic [MonthW-1:0] MonthJan  = 4'd1;
    localparam logic [MonthW-1:0] MonthLast = 4'd12;

    // Multiplicative inverse of 25 modulo 2^16 and the largest multiple-of-25 image
    localparam logic [YearW-1:0] Inv25     = 16'd23593;
    localparam logic [YearW-1:0] Div25Max  = 16'd2621;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LEAP_START,
        ST_NORM,
        ST_ADD,
        ST_ITER,
        ST_LEAP_YEAR,
        ST_DONE
    } cdad_state_t;

    // Shared adder operations
    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } cdad_alu_op_t;

    // Days in a month; month must be 1..12
    function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m, input logic leap);
        logic [DayW-1:0] n;
        begin
            case (m)
                4'd2:                   n = leap ? 5'd29 : 5'd28;
                4'd4, 4'd6, 4'd9, 4'd11: n = 5'd30;
                default:                n = 5'd31;
            endcase
            return n;
        end
    endfunction

endpackage

// ----- sv/cdad_leap.sv -----
// Registered Gregorian leap-year detector.
module cdad_leap
    import cdad_pkg::*;
(
    input  logic             aclk,
    input  logic [YearW-1:0] year,
    output logic             leap
);

    logic [YearW-1:0] prod;
    logic             div4;
    logic             div16;
    logic             div25;
    logic             leap_next;
    logic             leap_reg;

    // Divisibility by 25: y*inv(25) mod 2^16 lands low exactly for multiples
    always_comb begin
        prod      = YearW'(year * Inv25);
        div4      = (year[1:0] == 2'b00);
        div16     = (year[3:0] == 4'b0000);
        div25     = (prod <= Div25Max);
        // With div4 known: not a century, or a century divisible by 400
        leap_next = div4 && (!div25 || div16);
    end

    always_ff @(posedge aclk) begin
        leap_reg <= leap_next;
    end

    assign leap = leap_reg;

endmodule

// ----- sv/cdad_alu.sv -----
// Shared add/subtract unit for the day count.
module cdad_alu
    import cdad_pkg::*;
(
    input  cdad_alu_op_t      op,
    input  logic [AccW-1:0]   a,
    input  logic [AccW-1:0]   b,
    output logic [AccW-1:0]   res,
    output logic              borrow,
    output logic              zero
);

    logic [AccW:0] full;

    always_comb begin
        case (op)
            ALU_ADD: full = {1'b0, a} + {1'b0, b};
            ALU_SUB: full = {1'b0, a} - {1'b0, b};
            default: full = {1'b0, a};
        endcase
        res    = full[AccW-1:0];
        borrow = (op == ALU_SUB) && full[AccW];
        zero   = (full[AccW-1:0] == '0);
    end

endmodule

// ----- sv/calendar_date_add_days.sv -----
// Top level: Gregorian date advance by a day count, one month per step.
//
// Input channel s_*: one transfer carries a start date and a day count.
// The month is forced into 1..12 and a day beyond its month length becomes
// 1, then the day count is added and month lengths are taken off one month
// per cycle, with a wait at each year boundary, carrying into month and year.
// Output channel m_*: one transfer per input, day, month, year and a flag
// set if the year wrapped past 65535.
// After the input transfer the sequencer waits for the start year's leap flag,
// normalises the day and adds the day count, then steps over the months, with a
// wait state per year boundary crossed (the leap detector is registered), and
// presents the result. The largest day count steps about 2154 months and 180 years.
// The block takes one item at a time; s_tready is high only while idle,
// which begins in the cycle after the result transfer.
// Reset (aresetn low, synchronous) returns the sequencer to idle and drops
// m_tvalid. If the receiver holds m_tready low, the result stays on m_tdata
// and no new input is taken until it has been transferred.
module calendar_date_add_days
    import cdad_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // tdata: start_day[4:0], start_month[8:5], start_year[24:9], days_to_add[40:25]
    input  logic [InDataW-1:0]   s_tdata,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // tdata: day[4:0], month[8:5], year[24:9], year_overflow[25]
    output logic [OutDataW-1:0]  m_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready
);

    cdad_state_t       state_reg, state_next;
    logic [AccW-1:0]   day_reg, day_next;
    logic [MonthW-1:0] month_reg, month_next;
    logic [YearW-1:0]  year_reg, year_next;
    logic [AddW-1:0]   add_reg, add_next;
    logic              ovf_reg, ovf_next;

    logic [DayW-1:0]   in_day;
    logic [MonthW-1:0] in_month;
    logic [YearW-1:0]  in_year;
    logic [AddW-1:0]   in_add;

    logic              leap;
    logic [DayW-1:0]   mlen;
    cdad_alu_op_t      alu_op;
    logic [AccW-1:0]   alu_b;
    logic [AccW-1:0]   alu_res;
    logic              alu_borrow;
    logic              alu_zero;

    assign in_day   = s_tdata[4:0];
    assign in_month = s_tdata[8:5];
    assign in_year  = s_tdata[24:9];
    assign in_add   = s_tdata[40:25];

    cdad_leap u_leap (
        .aclk (aclk),
        .year (year_reg),
        .leap (leap)
    );

    assign mlen = month_len(month_reg, leap);

    cdad_alu u_alu (
        .op     (alu_op),
        .a      (day_reg),
        .b      (alu_b),
        .res    (alu_res),
        .borrow (alu_borrow),
        .zero   (alu_zero)
    );

    // Operand select for the shared unit
    always_comb begin
        if (state_reg == ST_ADD) begin
            alu_op = ALU_ADD;
            alu_b  = AccW'(add_reg);
        end else begin
            alu_op = ALU_SUB;
            alu_b  = AccW'(mlen);
        end
    end

    // Sequencer
    always_comb begin
        state_next = state_reg;
        day_next   = day_reg;
        month_next = month_reg;
        year_next  = year_reg;
        add_next   = add_reg;
        ovf_next   = ovf_reg;
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    day_next   = AccW'(in_day);
                    month_next = (in_month inside {[4'd1:4'd12]}) ? in_month : MonthJan;
                    year_next  = in_year;
                    add_next   = in_add;
                    ovf_next   = 1'b0;
                    state_next = ST_LEAP_START;
                end
            end
            // Leap flag of the start year settles
            ST_LEAP_START: state_next = ST_NORM;
            // Day beyond the month length becomes 1
            ST_NORM: begin
                if (!alu_borrow && !alu_zero) begin
                    day_next = AccW'(1);
                end
                state_next = ST_ADD;
            end
            ST_ADD: begin
                day_next   = alu_res;
                state_next = ST_ITER;
            end
            // Take off one month while the day does not fit
            ST_ITER: begin
                if (alu_borrow || alu_zero) begin
                    state_next = ST_DONE;
                end else begin
                    day_next = alu_res;
                    if (month_reg == MonthLast) begin
                        month_next = MonthJan;
                        year_next  = year_reg + 1'b1;
                        if (year_reg == '1) begin
                            ovf_next = 1'b1;
                        end
                        state_next = ST_LEAP_YEAR;
                    end else begin
                        month_next = month_reg + 1'b1;
                    end
                end
            end
            // New year: wait for its leap flag
            ST_LEAP_YEAR: state_next = ST_ITER;
            ST_DONE: begin
                m_tvalid = 1'b1;
                if (m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        day_reg   <= day_next;
        month_reg <= month_next;
        year_reg  <= year_next;
        add_reg   <= add_next;
        ovf_reg   <= ovf_next;
    end

    assign m_tdata = {6'd0, ovf_reg, year_reg, month_reg, day_reg[DayW-1:0]};

endmodule

// ----- sv/cdad_checker.sv -----
// Port-level checker for the date advance block, bound to the top level.
module cdad_checker
    import cdad_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    input  logic                s_tready,
    input  logic [OutDataW-1:0] m_tdata,
    input  logic                m_tvalid,
    input  logic                m_tready
);

    // Never taking input while a result is on offer
    a_one_side: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input taken while result pending");

    // After an input transfer the block is busy
    a_busy_after_in: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (!s_tready && !m_tvalid))
        else $error("not busy after input transfer");

    // After an output transfer the block is idle again
    a_idle_after_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready) |=> (s_tready && !m_tvalid))
        else $error("not idle after output transfer");

    // Result month within 1..12
    a_month_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[8:5] >= MonthJan && m_tdata[8:5] <= MonthLast))
        else $error("result month out of range");

    // Stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

endmodule

bind calendar_date_add_days cdad_checker u_cdad_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);

// ----- tb/sv/date_advance_checker.sv -----
// Checker for the date advance block: predicts every result and compares it field by field.
module date_advance_checker
    import cdad_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [InDataW-1:0]  s_tdata,
    input  logic                s_tvalid,
    input  logic                s_tready,
    input  logic [OutDataW-1:0] m_tdata,
    input  logic                m_tvalid,
    input  logic                m_tready,
    output int                  fail_count,
    output int                  due_count,
    output int                  dates_checked,
    output int                  wraps_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    // Input transfer, start_day in the lowest bits
    typedef struct packed {
        logic [InDataW-AddW-YearW-MonthW-DayW-1:0] pad;
        logic [AddW-1:0]                           days_to_add;
        logic [YearW-1:0]                          start_year;
        logic [MonthW-1:0]                         start_month;
        logic [DayW-1:0]                           start_day;
    } date_request_t;

    // Result transfer, day in the lowest bits
    typedef struct packed {
        logic [OutDataW-1-YearW-MonthW-DayW-1:0] pad;
        logic                                    wrapped;
        logic [YearW-1:0]                        year;
        logic [MonthW-1:0]                       month;
        logic [DayW-1:0]                         day;
    } date_result_t;

    // Dates predicted for transfers accepted but not yet returned
    date_result_t due_dates[$];

    function automatic bit gregorian_leap(input int unsigned y);
        return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    function automatic int unsigned days_in_month(input int unsigned m, input int unsigned y);
        if (m == MonthFeb) begin
            return gregorian_leap(y) ? 29 : 28;
        end
        if (m == 4 || m == 6 || m == 9 || m == 11) begin
            return 30;
        end
        return 31;
    endfunction

    // Normalise the start date, then walk forward one month at a time
    function automatic date_result_t advance_date(input date_request_t req);
        int unsigned  d;
        int unsigned  m;
        int unsigned  y;
        date_result_t r;
        d = req.start_day;
        m = req.start_month;
        y = req.start_year;
        r = '0;
        if (m < MonthJan || m > MonthLast) begin
            m = MonthJan;
        end
        if (d > days_in_month(m, y)) begin
            d = 1;
        end
        d += req.days_to_add;
        while (d > days_in_month(m, y)) begin
            d -= days_in_month(m, y);
            m++;
            if (m > MonthLast) begin
                m = MonthJan;
                // year 65535 rolls over to 0, which counts as a leap year
                if (y == 16'hFFFF) begin
                    y = 0;
                    r.wrapped = 1'b1;
                end else begin
                    y++;
                end
            end
        end
        r.day   = d[DayW-1:0];
        r.month = m[MonthW-1:0];
        r.year  = y[YearW-1:0];
        return r;
    endfunction

    task automatic note_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
        $display("result %0d: %s is %0d, expected %0d", dates_checked, what, got, want);
        fail_count++;
    endtask

    // Predict on each input transfer, compare on each result transfer
    always @(posedge aclk) begin
        date_result_t got;
        date_result_t want;
        if (!aresetn) begin
            due_dates.delete();
        end else begin
            if (s_tvalid && s_tready) begin
                due_dates.push_back(advance_date(date_request_t'(s_tdata)));
            end
            if (m_tvalid && m_tready) begin
                got = date_result_t'(m_tdata);
                if (due_dates.size() == 0) begin
                    note_mismatch("transfer with no date outstanding, tdata", m_tdata, 0);
                end else begin
                    want = due_dates.pop_front();
                    if (got.day !== want.day) begin
                        note_mismatch("day", got.day, want.day);
                    end
                    if (got.month !== want.month) begin
                        note_mismatch("month", got.month, want.month);
                    end
                    if (got.year !== want.year) begin
                        note_mismatch("year", got.year, want.year);
                    end
                    if (got.wrapped !== want.wrapped) begin
                        note_mismatch("year_overflow", got.wrapped, want.wrapped);
                    end
                    if (want.wrapped) begin
                        wraps_seen++;
                    end
                    dates_checked++;
                end
            end
        end
        due_count = due_dates.size();
    end

endmodule

// ----- tb/sv/testbench.sv -----
// Top of the date advance testbench: clock, reset, stimulus, back-pressure and verdict.
module testbench
    import cdad_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RandomDates = 250;
    localparam int LongHold    = 400;
    // Settling time after the last result, long enough for one more whole result
    localparam int DrainCycles = 2500;
    localparam int CycleLimit  = 3_000_000;

    logic                aclk;
    logic                aresetn;
    logic [InDataW-1:0]  s_tdata;
    logic                s_tvalid;
    logic                s_tready;
    logic [OutDataW-1:0] m_tdata;
    logic                m_tvalid;
    logic                m_tready;

    int fail_count;
    int due_count;
    int dates_checked;
    int wraps_seen;

    int cycle_count   = 0;
    int dates_sent    = 0;
    int long_holds    = 0;
    int hold_requests = 0;
    bit tx_calm       = 1'b0;
    bit rx_calm       = 1'b0;

    calendar_date_add_days i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    date_advance_checker i_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tdata       (s_tdata),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .m_tdata       (m_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .fail_count    (fail_count),
        .due_count     (due_count),
        .dates_checked (dates_checked),
        .wraps_seen    (wraps_seen)
    );

    // 2 ns clock
    always begin
        aclk = 1'b0;
        #1;
        aclk = 1'b1;
        #1;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    // Run-away guard
    initial begin
        wait (cycle_count >= CycleLimit);
        $display("timed out after %0d cycles with %0d dates outstanding", cycle_count, due_count);
        $display("status: fail");
        $finish;
    end

    // Idle length: mostly none or short, now and then long
    function automatic int idle_length();
        int roll;
        roll = $urandom_range(99);
        if (roll < 55) begin
            return 0;
        end
        if (roll < 85) begin
            return $urandom_range(3, 1);
        end
        if (roll < 96) begin
            return $urandom_range(12, 4);
        end
        return $urandom_range(80, 20);
    endfunction

    // Offer one date, after an optional gap, and return once it is transferred
    task automatic send_date(input logic [DayW-1:0] d, input logic [MonthW-1:0] m,
                             input logic [YearW-1:0] y, input logic [AddW-1:0] n);
        int gap;
        gap = tx_calm ? 0 : idle_length();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tdata  <= {{(InDataW-AddW-YearW-MonthW-DayW){1'b0}}, n, y, m, d};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        dates_sent++;
    endtask

    // Receiver: random stalls, or one long hold-off on request
    initial begin
        int hold;
        hold     = 0;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_requests > long_holds) begin
                hold = LongHold;
                long_holds++;
            end
            if (hold > 0) begin
                m_tready <= 1'b0;
                hold--;
            end else if (rx_calm || $urandom_range(99) < 70) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b0;
                hold = idle_length();
            end
        end
    end

    // Stimulus and verdict
    initial begin
        logic [DayW-1:0]   d;
        logic [MonthW-1:0] m;
        logic [YearW-1:0]  y;
        logic [AddW-1:0]   n;
        int                roll;
        int                phase;

        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: field extremes, day zero, leap rules, bad months, year wrap
        send_date(5'd1,  4'd1,  16'd2024,  16'd0);
        send_date(5'd0,  4'd0,  16'd0,     16'd0);
        send_date(5'd31, 4'd15, 16'hFFFF,  16'hFFFF);
        send_date(5'd0,  4'd5,  16'd2023,  16'd0);
        send_date(5'd0,  4'd5,  16'd2023,  16'd3);
        send_date(5'd29, 4'd2,  16'd2024,  16'd0);
        send_date(5'd29, 4'd2,  16'd2023,  16'd0);
        send_date(5'd29, 4'd2,  16'd1900,  16'd0);
        send_date(5'd29, 4'd2,  16'd2000,  16'd0);
        send_date(5'd28, 4'd2,  16'd2023,  16'd1);
        send_date(5'd28, 4'd2,  16'd2024,  16'd1);
        send_date(5'd28, 4'd2,  16'd2100,  16'd1);
        send_date(5'd31, 4'd4,  16'd2023,  16'd0);
        send_date(5'd15, 4'd0,  16'd2023,  16'd0);
        send_date(5'd15, 4'd13, 16'd2023,  16'd0);
        send_date(5'd31, 4'd12, 16'hFFFF,  16'd0);
        send_date(5'd31, 4'd12, 16'hFFFF,  16'd1);
        send_date(5'd28, 4'd2,  16'hFFFF,  16'd1);
        send_date(5'd28, 4'd2,  16'd0,     16'd1);
        send_date(5'd31, 4'd1,  16'd0,     16'hFFFF);
        send_date(5'd31, 4'd12, 16'hFFFF,  16'hFFFF);
        send_date(5'd1,  4'd3,  16'd1999,  16'd366);

        // Random dates in four phases: normal, no idling, long hold-off, normal
        for (int i = 0; i < RandomDates; i++) begin
            phase   = i / (RandomDates / 4);
            tx_calm = (phase == 1);
            rx_calm = (phase == 1);
            if (i == 2 * RandomDates / 4 + 5) begin
                // receiver stops while we keep offering, so the block backs up
                hold_requests++;
            end
            if (i == 3 * RandomDates / 4 + 5) begin
                // let every result drain before carrying on
                s_tvalid <= 1'b0;
                wait (due_count == 0);
                @(negedge aclk);
            end

            roll = $urandom_range(99);
            d = (roll < 70) ? DayW'($urandom_range(31)) : DayW'($urandom_range(31, 27));
            roll = $urandom_range(99);
            m = (roll < 85) ? MonthW'($urandom_range(12, 1)) : MonthW'($urandom_range(15));
            roll = $urandom_range(99);
            if (roll < 50) begin
                y = YearW'($urandom_range(16'hFFFF));
            end else if (roll < 70) begin
                y = YearW'($urandom_range(16'hFFFF, 16'hFF00));
            end else if (roll < 85) begin
                y = YearW'($urandom_range(655) * 100);
            end else begin
                y = YearW'($urandom_range(16383) * 4);
            end
            // Mostly short advances keep the run quick; a few span the whole range
            roll = $urandom_range(99);
            if (roll < 35) begin
                n = AddW'($urandom_range(40));
            end else if (roll < 65) begin
                n = AddW'($urandom_range(400));
            end else if (roll < 85) begin
                n = AddW'($urandom_range(4000));
            end else begin
                n = AddW'($urandom_range(16'hFFFF));
            end
            send_date(d, m, y, n);
        end
        s_tvalid <= 1'b0;

        // Drain, then allow time for any stray transfer
        wait (due_count == 0);
        repeat (DrainCycles) @(posedge aclk);

        $display("%0d dates sent, %0d results checked, %0d of them across the year wrap",
                 dates_sent, dates_checked, wraps_seen);
        $display("covered bad months, day zero, leap and century Februaries, %0d long hold-off",
                 long_holds);
        if (fail_count == 0 && due_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
